### sv/esc_pkg.sv
// Shared constants, register indexes, class codes and control bundles.
package esc_pkg;

  // Default sizing of the block.
  localparam int ESC_MAX_COLUMNS      = 4096;
  localparam int ESC_WEIGHT_FRAC_BITS = 16;

  // Field widths that the interface fixes.
  localparam int SUM_IN_W = 16;
  localparam int NOBJ_W   = 16;
  localparam int THR_W    = 16;
  localparam int BASE_W   = 4;
  localparam int ADDR_W   = 4;
  localparam int APB_W    = 32;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_N_OBJECTS     = 2'd0;
  localparam logic [1:0] REG_THRESHOLD     = 2'd1;
  localparam logic [1:0] REG_WEIGHT_FACTOR = 2'd2;

  // Column classes.
  localparam logic [1:0] CLS_ONE  = 2'd0;
  localparam logic [1:0] CLS_ZERO = 2'd1;
  localparam logic [1:0] CLS_DIS  = 2'd2;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [NOBJ_W-1:0] n_objects;
    logic [THR_W-1:0]  threshold;
    logic [BASE_W-1:0] weight_factor;
  } esc_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic setup;
    logic frac_step;
    logic pow_step;
    logic accumulate;
    logic load_out;
  } esc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic use_frac;
    logic frac_last;
    logic pow_done;
    logic last;
  } esc_status_t;

endpackage

### sv/esc_regs.sv
// APB configuration registers: object count, threshold and weight base.
module esc_regs
  import esc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready,
  output esc_cfg_t          cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.n_objects     <= NOBJ_W'(1);
      cfg.threshold     <= '0;
      cfg.weight_factor <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_N_OBJECTS:     cfg.n_objects     <= pwdata[NOBJ_W-1:0];
        REG_THRESHOLD:     cfg.threshold     <= pwdata[THR_W-1:0];
        REG_WEIGHT_FACTOR: cfg.weight_factor <= pwdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_idx)
      REG_N_OBJECTS:     prdata = APB_W'(cfg.n_objects);
      REG_THRESHOLD:     prdata = APB_W'(cfg.threshold);
      REG_WEIGHT_FACTOR: prdata = APB_W'(cfg.weight_factor);
      default:           prdata = '0;
    endcase
  end

endmodule

### sv/esc_ctrl.sv
// Controller state machine: sequences capture, weight unit, accumulation and output.
module esc_ctrl
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  esc_status_t status,
  output esc_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_FRAC  = 3'd2;
  localparam logic [2:0] ST_POW   = 3'd3;
  localparam logic [2:0] ST_ACC   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign out_free = !out_valid || m_tready;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = status.use_frac ? ST_FRAC : ST_POW;
      end
      ST_FRAC: begin
        cmd.frac_step = 1'b1;
        if (status.frac_last) begin
          state_next = ST_ACC;
        end
      end
      ST_POW: begin
        if (status.pow_done) begin
          state_next = ST_ACC;
        end else begin
          cmd.pow_step = 1'b1;
        end
      end
      ST_ACC: begin
        cmd.accumulate = 1'b1;
        state_next     = status.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid flag; the output register is free once its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // An accepted beat always moves on to weight setup.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_SETUP))
    else $error("accepted beat did not enter setup");

  // The last division step hands over to accumulation.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FRAC && status.frac_last) |=> (state == ST_ACC))
    else $error("fraction division did not finish into accumulation");

  // A new result only appears after the emit state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_EMIT))
    else $error("output valid rose outside emit");

  // The output register is never overwritten while its beat waits.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || m_tready))
    else $error("output overwritten while stalled");

endmodule

### sv/esc_dp.sv
// Datapath: classification, shared weight unit, class totals and output register.
module esc_dp
  import esc_pkg::*;
#(
  parameter int WEIGHT_FRAC_BITS = ESC_WEIGHT_FRAC_BITS,
  parameter int CNT_W            = 13,
  parameter int SUM_W            = 29
) (
  input  logic                clk,
  input  logic                rst,
  input  esc_cfg_t            cfg,
  input  logic [SUM_IN_W-1:0] column_sum,
  input  logic                last_column,
  input  esc_cmd_t            cmd,
  output esc_status_t         status,
  output logic [CNT_W-1:0]    count_one_sim,
  output logic [CNT_W-1:0]    count_zero_sim,
  output logic [CNT_W-1:0]    count_dissim,
  output logic [SUM_W-1:0]    weight_one_sim,
  output logic [SUM_W-1:0]    weight_zero_sim,
  output logic [SUM_W-1:0]    weight_dissim
);

  // Weight width holds 1.0; reciprocal scale makes the multiply exact for bases up to 15.
  localparam int WW    = WEIGHT_FRAC_BITS + 1;
  localparam int RK    = WW + 4;
  localparam int RW    = RK;
  localparam int PW    = WW + RW;
  localparam int DCW   = $clog2(WW);
  localparam int S_W   = SUM_IN_W + 1;
  localparam longint unsigned SCALE = 64'd1 << RK;
  localparam logic [RW-1:0] RECIP [16] = '{
    RW'(0), RW'(0),
    RW'((SCALE + 1) / 2),   RW'((SCALE + 2) / 3),   RW'((SCALE + 3) / 4),
    RW'((SCALE + 4) / 5),   RW'((SCALE + 5) / 6),   RW'((SCALE + 6) / 7),
    RW'((SCALE + 7) / 8),   RW'((SCALE + 8) / 9),   RW'((SCALE + 9) / 10),
    RW'((SCALE + 10) / 11), RW'((SCALE + 11) / 12), RW'((SCALE + 12) / 13),
    RW'((SCALE + 13) / 14), RW'((SCALE + 14) / 15)
  };
  localparam logic [WW-1:0] ONE_W = WW'(1) << WEIGHT_FRAC_BITS;

  // Captured item.
  logic [SUM_IN_W-1:0] sum_q;
  logic                last_q;

  // Setup decode.
  logic signed [S_W:0] diff;
  logic signed [S_W:0] ndiff;
  logic signed [S_W:0] thr_s;
  logic                is_one;
  logic                is_zero;
  logic [S_W-1:0]      s_abs;
  logic [S_W-1:0]      m_dist;
  logic [S_W-1:0]      n_ext;
  logic [1:0]          cls_d;
  logic                frac_d;
  logic [S_W-1:0]      x_d;
  logic [S_W-1:0]      exp_d;

  // Weight unit state.
  logic [1:0]       cls;
  logic             mode_frac;
  logic [S_W-1:0]   rem;
  logic             first;
  logic [DCW-1:0]   dcnt;
  logic [WW-1:0]    quo;
  logic [S_W:0]     trial;
  logic             ge;
  logic [S_W:0]     trial_sub;
  logic [WW-1:0]    pval;
  logic [S_W-1:0]   pexp;
  logic [BASE_W-1:0] base;
  logic [PW-1:0]    prod;
  logic [WW-1:0]    weight;

  // Class totals.
  logic [CNT_W-1:0] tot_cnt_one;
  logic [CNT_W-1:0] tot_cnt_zero;
  logic [CNT_W-1:0] tot_cnt_dis;
  logic [SUM_W-1:0] tot_w_one;
  logic [SUM_W-1:0] tot_w_zero;
  logic [SUM_W-1:0] tot_w_dis;
  logic [CNT_W-1:0] cnt_sel;
  logic [SUM_W-1:0] w_sel;
  logic [CNT_W-1:0] cnt_inc;
  logic [SUM_W:0]   w_add;
  logic [SUM_W-1:0] w_sat;

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sum_q  <= column_sum;
      last_q <= last_column;
    end
  end

  // Classify the column and pick the weight job.
  always_comb begin
    n_ext   = S_W'(cfg.n_objects);
    diff    = $signed({1'b0, sum_q, 1'b0}) - $signed({2'b00, cfg.n_objects});
    ndiff   = -diff;
    thr_s   = $signed({2'b00, cfg.threshold});
    is_one  = diff > thr_s;
    is_zero = !is_one && (ndiff > thr_s);
    s_abs   = diff[S_W] ? ndiff[S_W-1:0] : diff[S_W-1:0];
    m_dist  = (s_abs > S_W'(cfg.n_objects[0])) ? s_abs - S_W'(cfg.n_objects[0]) : '0;
    cls_d   = is_one ? CLS_ONE : (is_zero ? CLS_ZERO : CLS_DIS);
    frac_d  = 1'b0;
    x_d     = '0;
    exp_d   = '0;
    if (cfg.weight_factor != '0) begin
      // Power weights; base one and non-positive exponents give 1.0.
      if (cfg.weight_factor == BASE_W'(1)) begin
        exp_d = '0;
      end else if (cls_d != CLS_DIS) begin
        exp_d = (s_abs >= n_ext) ? '0 : n_ext - s_abs;
      end else begin
        exp_d = m_dist;
      end
    end else if (cfg.n_objects != '0) begin
      // Fraction weights; saturated cases go through the power path with no steps.
      if (cls_d != CLS_DIS) begin
        if (s_abs < n_ext) begin
          frac_d = 1'b1;
          x_d    = s_abs;
        end
      end else begin
        frac_d = 1'b1;
        x_d    = (m_dist >= n_ext) ? '0 : n_ext - m_dist;
      end
    end
  end

  // Restoring division step and reciprocal multiply step.
  always_comb begin
    trial     = first ? {1'b0, rem} : {rem, 1'b0};
    ge        = trial >= {1'b0, n_ext};
    trial_sub = trial - {1'b0, n_ext};
    prod      = PW'(pval) * PW'(RECIP[base]);
  end

  // Weight unit registers.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      cls       <= cls_d;
      mode_frac <= frac_d;
      rem       <= x_d;
      first     <= 1'b1;
      dcnt      <= DCW'(WW - 1);
      quo       <= '0;
      pval      <= ONE_W;
      pexp      <= exp_d;
      base      <= cfg.weight_factor;
    end else begin
      if (cmd.frac_step) begin
        rem   <= ge ? trial_sub[S_W-1:0] : trial[S_W-1:0];
        quo   <= {quo[WW-2:0], ge};
        first <= 1'b0;
        dcnt  <= dcnt - DCW'(1);
      end
      if (cmd.pow_step) begin
        pval <= prod[RK +: WW];
        pexp <= pexp - S_W'(1);
      end
    end
  end

  assign weight           = mode_frac ? quo : pval;
  assign status.use_frac  = frac_d;
  assign status.frac_last = (dcnt == '0);
  assign status.pow_done  = (pexp == '0) || (pval == '0);
  assign status.last      = last_q;

  // Saturating update of the selected class.
  always_comb begin
    case (cls)
      CLS_ONE: begin
        cnt_sel = tot_cnt_one;
        w_sel   = tot_w_one;
      end
      CLS_ZERO: begin
        cnt_sel = tot_cnt_zero;
        w_sel   = tot_w_zero;
      end
      default: begin
        cnt_sel = tot_cnt_dis;
        w_sel   = tot_w_dis;
      end
    endcase
    cnt_inc = (cnt_sel == '1) ? cnt_sel : cnt_sel + CNT_W'(1);
    w_add   = {1'b0, w_sel} + (SUM_W + 1)'(weight);
    w_sat   = w_add[SUM_W] ? '1 : w_add[SUM_W-1:0];
  end

  // Class totals; cleared when a result is loaded.
  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      tot_cnt_one  <= '0;
      tot_cnt_zero <= '0;
      tot_cnt_dis  <= '0;
      tot_w_one    <= '0;
      tot_w_zero   <= '0;
      tot_w_dis    <= '0;
    end else if (cmd.accumulate) begin
      case (cls)
        CLS_ONE: begin
          tot_cnt_one <= cnt_inc;
          tot_w_one   <= w_sat;
        end
        CLS_ZERO: begin
          tot_cnt_zero <= cnt_inc;
          tot_w_zero   <= w_sat;
        end
        default: begin
          tot_cnt_dis <= cnt_inc;
          tot_w_dis   <= w_sat;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      count_one_sim   <= tot_cnt_one;
      count_zero_sim  <= tot_cnt_zero;
      count_dissim    <= tot_cnt_dis;
      weight_one_sim  <= tot_w_one;
      weight_zero_sim <= tot_w_zero;
      weight_dissim   <= tot_w_dis;
    end
  end

endmodule

### sv/extended_similarity_counters.sv
// Top level of the extended-similarity counters: streaming ports, APB registers, core.
//
// Each column sum is classed as 1-similar, 0-similar or dissimilar and adds a
// Q1.16 weight to that class's total; a column with tlast also sends the six
// totals as one output beat and clears them. An item passes through capture,
// setup, WEIGHT_FRAC_BITS+1 restoring division steps and accumulate when a
// fraction division runs, and through capture, setup, k reciprocal-multiply
// steps and accumulate on the power path, where k is at most WEIGHT_FRAC_BITS+1;
// a fraction weight that saturates at 1.0 takes the power path with no steps.
// A last column then waits in the emit state for the output register to drain.
// The divide/multiply weight unit is shared by both paths.
// The input side accepts the next column while a result beat waits on the output.
module extended_similarity_counters
  import esc_pkg::*;
#(
  parameter  int MAX_COLUMNS      = ESC_MAX_COLUMNS,
  parameter  int WEIGHT_FRAC_BITS = ESC_WEIGHT_FRAC_BITS,
  localparam int CNT_W            = $clog2(MAX_COLUMNS + 1),
  localparam int SUM_W            = CNT_W + WEIGHT_FRAC_BITS,
  localparam int OUT_BITS         = 3 * (CNT_W + SUM_W),
  localparam int TDATA_W          = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SUM_IN_W-1:0] s_tdata,   // column_sum
  input  logic                s_tlast,   // last_column
  output logic                m_tvalid,
  input  logic                m_tready,
  // count_one_sim, count_zero_sim, count_dissim, weight_one_sim, weight_zero_sim,
  // weight_dissim, then zero fill
  output logic [TDATA_W-1:0]  m_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [APB_W-1:0]    pwdata,
  output logic [APB_W-1:0]    prdata,
  output logic                pready
);

  esc_cfg_t         cfg;
  esc_cmd_t         cmd;
  esc_status_t      status;
  logic [CNT_W-1:0] count_one_sim;
  logic [CNT_W-1:0] count_zero_sim;
  logic [CNT_W-1:0] count_dissim;
  logic [SUM_W-1:0] weight_one_sim;
  logic [SUM_W-1:0] weight_zero_sim;
  logic [SUM_W-1:0] weight_dissim;

  esc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  esc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  esc_dp #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
    .CNT_W            (CNT_W),
    .SUM_W            (SUM_W)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .column_sum      (s_tdata),
    .last_column     (s_tlast),
    .cmd             (cmd),
    .status          (status),
    .count_one_sim   (count_one_sim),
    .count_zero_sim  (count_zero_sim),
    .count_dissim    (count_dissim),
    .weight_one_sim  (weight_one_sim),
    .weight_zero_sim (weight_zero_sim),
    .weight_dissim   (weight_dissim)
  );

  // Pack the result beat, first field in the lowest bits.
  assign m_tdata = TDATA_W'({weight_dissim, weight_zero_sim, weight_one_sim,
                             count_dissim, count_zero_sim, count_one_sim});

endmodule

### bench/esc_checker.sv
// Checker for the extended-similarity counters: watches the streams and APB, predicts the totals.
module esc_checker
  import esc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [SUM_IN_W-1:0] s_tdata,   // column_sum
  input  logic                s_tlast,   // last_column
  input  logic                m_tvalid,
  input  logic                m_tready,
  // count_one_sim, count_zero_sim, count_dissim, weight_one_sim, weight_zero_sim,
  // weight_dissim, then zero fill
  input  logic [127:0]        m_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [APB_W-1:0]    pwdata,
  input  logic [APB_W-1:0]    prdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  totals_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_W = 13;
  localparam int SUM_W = 29;
  localparam longint unsigned ONE_W = 64'd1 << ESC_WEIGHT_FRAC_BITS;
  localparam longint unsigned COUNT_MAX = (64'd1 << CNT_W) - 1;
  localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 1;

  // Running totals of one fingerprint matrix.
  typedef struct packed {
    logic [CNT_W-1:0] one_cnt;
    logic [CNT_W-1:0] zero_cnt;
    logic [CNT_W-1:0] dis_cnt;
    logic [SUM_W-1:0] one_wt;
    logic [SUM_W-1:0] zero_wt;
    logic [SUM_W-1:0] dis_wt;
  } totals_t;

  // Shadow of the configuration registers.
  logic [NOBJ_W-1:0] n_obj;
  logic [THR_W-1:0]  thr;
  logic [BASE_W-1:0] base;

  totals_t acc;
  totals_t frame_totals_q[$];
  int      mismatches = 0;

  const string FIELD_NAME[6] = '{"count_one_sim", "count_zero_sim", "count_dissim",
                                 "weight_one_sim", "weight_zero_sim", "weight_dissim"};
  const int FIELD_W[6] = '{CNT_W, CNT_W, CNT_W, SUM_W, SUM_W, SUM_W};

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
  endtask

  // Weight 1.0 divided by the base, truncating, until the exponent or the value runs out.
  function automatic longint unsigned power_weight(input longint unsigned b,
                                                   input longint unsigned ex);
    longint unsigned v;
    v = ONE_W;
    if (b <= 1)
      return ONE_W;
    while (ex > 0 && v != 0) begin
      v = v / b;
      ex--;
    end
    return v;
  endfunction

  function automatic longint unsigned similar_weight(input longint unsigned s);
    longint unsigned n;
    n = n_obj;
    if (base != 0) begin
      if (s >= n)
        return ONE_W;
      return power_weight(base, n - s);
    end
    if (n == 0 || s >= n)
      return ONE_W;
    return (s << ESC_WEIGHT_FRAC_BITS) / n;
  endfunction

  function automatic longint unsigned dissimilar_weight(input longint unsigned s);
    longint unsigned n, p, m;
    n = n_obj;
    p = n & 1;
    m = (s > p) ? s - p : 0;
    if (base != 0)
      return power_weight(base, m);
    if (n == 0)
      return ONE_W;
    if (m >= n)
      return 0;
    return ((n - m) << ESC_WEIGHT_FRAC_BITS) / n;
  endfunction

  function automatic longint unsigned sat_add(input longint unsigned a, input longint unsigned b,
                                              input longint unsigned lim);
    return (a + b > lim) ? lim : a + b;
  endfunction

  // Classify one column, add it to its class, and queue the totals on the last column.
  task automatic fold_column(input logic [SUM_IN_W-1:0] sum, input logic last);
    longint          sv, nv, tv, diff;
    longint unsigned s;
    logic [1:0]      cls;
    sv = sum;
    nv = n_obj;
    tv = thr;
    diff = 2 * sv - nv;
    if (diff > tv)
      cls = CLS_ONE;
    else if (-diff > tv)
      cls = CLS_ZERO;
    else
      cls = CLS_DIS;
    s = (diff < 0) ? -diff : diff;
    case (cls)
      CLS_ONE: begin
        acc.one_cnt = CNT_W'(sat_add(acc.one_cnt, 1, COUNT_MAX));
        acc.one_wt  = SUM_W'(sat_add(acc.one_wt, similar_weight(s), SUM_MAX));
      end
      CLS_ZERO: begin
        acc.zero_cnt = CNT_W'(sat_add(acc.zero_cnt, 1, COUNT_MAX));
        acc.zero_wt  = SUM_W'(sat_add(acc.zero_wt, similar_weight(s), SUM_MAX));
      end
      default: begin
        acc.dis_cnt = CNT_W'(sat_add(acc.dis_cnt, 1, COUNT_MAX));
        acc.dis_wt  = SUM_W'(sat_add(acc.dis_wt, dissimilar_weight(s), SUM_MAX));
      end
    endcase
    if (last) begin
      frame_totals_q.push_back(acc);
      acc = '0;
    end
  endtask

  // Compare one output beat with the oldest queued totals, field by field.
  task automatic check_beat();
    totals_t     t;
    logic [63:0] want[6];
    logic [63:0] got[6];
    int          off;
    if (frame_totals_q.size() == 0) begin
      note_mismatch("result beats", 0, 1);
      return;
    end
    t = frame_totals_q.pop_front();
    want = '{t.one_cnt, t.zero_cnt, t.dis_cnt, t.one_wt, t.zero_wt, t.dis_wt};
    off = 0;
    for (int i = 0; i < 6; i++) begin
      got[i] = 64'((m_tdata >> off) & ((128'd1 << FIELD_W[i]) - 1));
      off += FIELD_W[i];
      if (got[i] !== want[i])
        note_mismatch(FIELD_NAME[i], want[i], got[i]);
    end
  endtask

  function automatic logic [APB_W-1:0] shadow_value(input logic [1:0] idx);
    case (idx)
      REG_N_OBJECTS:     return APB_W'(n_obj);
      REG_THRESHOLD:     return APB_W'(thr);
      REG_WEIGHT_FACTOR: return APB_W'(base);
      default:           return '0;
    endcase
  endfunction

  // Sample every channel at the clock edge; results leave before new columns are folded in.
  always @(posedge clk) begin
    if (rst) begin
      n_obj = 1;
      thr   = 0;
      base  = 0;
      acc   = '0;
      frame_totals_q.delete();
    end else begin
      if (m_tvalid && m_tready)
        check_beat();
      if (s_tvalid && s_tready)
        fold_column(s_tdata, s_tlast);
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[ADDR_W-1:2])
            REG_N_OBJECTS:     n_obj = pwdata[NOBJ_W-1:0];
            REG_THRESHOLD:     thr   = pwdata[THR_W-1:0];
            REG_WEIGHT_FACTOR: base  = pwdata[BASE_W-1:0];
            default: ;
          endcase
        end else if (prdata !== shadow_value(paddr[ADDR_W-1:2])) begin
          note_mismatch("register read", shadow_value(paddr[ADDR_W-1:2]), prdata);
        end
      end
    end
    totals_waiting <= frame_totals_q.size();
    fail_count     <= mismatches;
  end

endmodule

### bench/extended_similarity_counters_tb.sv
// Testbench top for the extended-similarity counters: clock, reset, stimulus and verdict.
module extended_similarity_counters_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE      = 40;
  localparam int RANDOM_ITEMS = 1820;

  typedef enum int {RX_FREE, RX_HALF, RX_SLOW} rx_mode_e;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [esc_pkg::SUM_IN_W-1:0]  s_tdata;   // column_sum
  logic                          s_tlast;   // last_column
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  // count_one_sim, count_zero_sim, count_dissim, weight_one_sim, weight_zero_sim,
  // weight_dissim, then zero fill
  logic [127:0]                  m_tdata;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [esc_pkg::ADDR_W-1:0]    paddr;
  logic [esc_pkg::APB_W-1:0]     pwdata;
  logic [esc_pkg::APB_W-1:0]     prdata;
  logic                          pready;

  int          fail_count;
  int          totals_waiting;
  int          cycle_count = 0;
  bit          tx_active;
  int unsigned burst_left;
  rx_mode_e    rx_mode = RX_FREE;
  int unsigned rx_left = 0;

  extended_similarity_counters u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  esc_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count, .totals_waiting
  );

  always #6 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result receiver: stretches of free flow, even stalling and heavy stalling.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = $urandom_range(16, 200);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_FREE: m_tready <= 1'b1;
        RX_HALF: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // One APB transfer: setup cycle, access cycle, then back to idle.
  task automatic apb_transfer(input bit wr, input logic [1:0] idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write all three registers, then read them back.
  task automatic configure(input int unsigned n, input int unsigned t, input int unsigned w);
    apb_transfer(1'b1, esc_pkg::REG_N_OBJECTS, n);
    apb_transfer(1'b1, esc_pkg::REG_THRESHOLD, t);
    apb_transfer(1'b1, esc_pkg::REG_WEIGHT_FACTOR, w);
    apb_transfer(1'b0, esc_pkg::REG_N_OBJECTS, 0);
    apb_transfer(1'b0, esc_pkg::REG_THRESHOLD, 0);
    apb_transfer(1'b0, esc_pkg::REG_WEIGHT_FACTOR, 0);
  endtask

  // Send one column beat; the sender runs in bursts with random gaps between them.
  task automatic send_column(input logic [15:0] sum, input logic last);
    if (!tx_active) begin
      s_tvalid  <= 1'b1;
      tx_active = 1'b1;
    end
    s_tdata <= sum;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0)
      burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid  <= 1'b0;
        tx_active = 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  endtask

  // Stop sending and let every queued result and any trailing work drain.
  task automatic drain();
    if (tx_active) begin
      s_tvalid  <= 1'b0;
      tx_active = 1'b0;
    end
    do @(posedge clk); while (totals_waiting != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Column sums that favor the class boundaries, with some beyond n.
  function automatic logic [15:0] pick_sum(input int n, input int t);
    int cut;
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'd0;
      2: return 16'(n);
      3, 4, 5: begin
        cut = (n + t) / 2 + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1) != 0)
          cut = n - cut;
        if (cut < 0)
          cut = 0;
        if (cut > 65535)
          cut = 65535;
        return 16'(cut);
      end
      default: return 16'($urandom_range(0, n));
    endcase
  endfunction

  initial begin
    int unsigned n_cfg, thr_cfg, wf_cfg, frames, len, sent;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    tx_active  = 1'b0;
    burst_left = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset values of the registers, then a frame under them.
    apb_transfer(1'b0, esc_pkg::REG_N_OBJECTS, 0);
    apb_transfer(1'b0, esc_pkg::REG_THRESHOLD, 0);
    apb_transfer(1'b0, esc_pkg::REG_WEIGHT_FACTOR, 0);
    send_column(16'd0, 1'b0);
    send_column(16'd1, 1'b1);
    drain();

    // Fraction weights, every class, a sum above n.
    configure(10, 2, 0);
    send_column(16'd10, 1'b0);
    send_column(16'd7, 1'b0);
    send_column(16'd5, 1'b0);
    send_column(16'd6, 1'b0);
    send_column(16'd2, 1'b0);
    send_column(16'd0, 1'b0);
    send_column(16'd65535, 1'b0);
    send_column(16'd4, 1'b1);
    drain();

    // Odd n, largest threshold: distance below parity and fraction past zero.
    configure(7, 65535, 0);
    send_column(16'd3, 1'b0);
    send_column(16'd0, 1'b0);
    send_column(16'd20, 1'b0);
    send_column(16'd65535, 1'b1);
    drain();

    // Zero objects: the weight saturates to 1.0 without a division.
    configure(0, 0, 0);
    send_column(16'd0, 1'b0);
    send_column(16'd5, 1'b1);
    drain();

    // Largest n and base: power weights that clamp at zero.
    configure(65535, 100, 15);
    send_column(16'd65535, 1'b0);
    send_column(16'd65000, 1'b0);
    send_column(16'd32767, 1'b0);
    send_column(16'd32800, 1'b0);
    send_column(16'd65530, 1'b0);
    send_column(16'd0, 1'b1);
    drain();

    // Base one always weighs 1.0.
    configure(20, 1, 1);
    send_column(16'd15, 1'b0);
    send_column(16'd10, 1'b0);
    send_column(16'd0, 1'b1);
    drain();

    // Base two with a short exponent.
    configure(5, 0, 2);
    send_column(16'd4, 1'b0);
    send_column(16'd2, 1'b0);
    send_column(16'd0, 1'b1);
    drain();

    // Random settings, each followed by several frames of random columns.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       n_cfg = 0;
        1:       n_cfg = 1;
        2:       n_cfg = 65535;
        3:       n_cfg = $urandom_range(2, 65535);
        4:       n_cfg = $urandom_range(65, 3000);
        default: n_cfg = $urandom_range(1, 40);
      endcase
      case ($urandom_range(0, 5))
        0:       thr_cfg = 0;
        1:       thr_cfg = 65535;
        2:       thr_cfg = $urandom_range(0, 3);
        default: thr_cfg = $urandom_range(0, n_cfg);
      endcase
      case ($urandom_range(0, 5))
        0, 1:    wf_cfg = 0;
        2:       wf_cfg = 1;
        3:       wf_cfg = 15;
        default: wf_cfg = $urandom_range(2, 14);
      endcase
      configure(n_cfg, thr_cfg, wf_cfg);
      frames = $urandom_range(3, 10);
      for (int f = 0; f < frames; f++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
        for (int k = 1; k <= len; k++)
          send_column(pick_sum(n_cfg, thr_cfg), k == len);
        sent += len;
      end
      drain();
    end

    if (fail_count == 0 && totals_waiting == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
sv/esc_pkg.sv
sv/esc_regs.sv
sv/esc_ctrl.sv
sv/esc_dp.sv
sv/extended_similarity_counters.sv
bench/esc_checker.sv
bench/extended_similarity_counters_tb.sv
